[hw/rtl/utf8_to_utf16_bmp_decoder_defines.svh]
// Assertion helpers shared by the decoder modules.
// Each macro expects clk and rst_n in scope.
`ifndef UTF8_TO_UTF16_BMP_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_BMP_DECODER_DEFINES_SVH

// Same-cycle implication.
`define U8U16_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/u8u16_pkg.sv]
package u8u16_pkg;

    localparam int MAX_RESULTS  = 3;
    localparam int HELD_MAX     = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [10:0] TWO_BYTE_MIN   = 11'h080;
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] unit_t;

    // One queue entry: all results caused by one accepted byte.
    typedef struct packed {
        logic [1:0]                   n;
        logic                         fin;
        logic [MAX_RESULTS-1:0][15:0] units;
    } entry_t;

    typedef struct packed {
        logic [1:0]                   n;
        logic [MAX_RESULTS-1:0][15:0] units;
        logic [1:0]                   rem_cnt;
        logic [HELD_MAX-1:0][7:0]     rem;
    } step_t;

    function automatic logic is_cont(input byte_t b);
        return b[7:6] == 2'b10;
    endfunction

    // Walk the pending bytes plus the new byte, emitting up to three units.
    function automatic step_t decode_step(input logic [3:0][7:0] bufs,
                                          input logic [1:0] cnt,
                                          input logic fin);
        step_t       r;
        logic [1:0]  head;
        logic        stop;
        logic [1:0]  avail;
        logic [1:0]  i1;
        logic [1:0]  i2;
        byte_t       lead;
        byte_t       b1;
        byte_t       b2;
        unit_t       unit;
        logic [1:0]  used;
        logic [10:0] v2;
        logic [15:0] v3;
        r    = '0;
        head = '0;
        stop = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (!stop && head < cnt)
            begin
                avail = cnt - head;
                i1    = head + 2'd1;
                i2    = head + 2'd2;
                lead  = bufs[head];
                b1    = bufs[i1];
                b2    = bufs[i2];
                unit  = '0;
                used  = 2'd1;
                v2    = {lead[4:0], b1[5:0]};
                v3    = {lead[3:0], b1[5:0], b2[5:0]};
                if (!lead[7])
                begin
                    unit = {8'h00, lead};
                end
                else if (lead[7:5] == 3'b110)
                begin
                    if (avail < 2'd2)
                    begin
                        if (!fin)
                            stop = 1'b1;
                    end
                    else if (is_cont(b1) && v2 >= TWO_BYTE_MIN)
                    begin
                        unit = {5'b00000, v2};
                        used = 2'd2;
                    end
                end
                else if (lead[7:4] == 4'b1110)
                begin
                    if (avail >= 2'd2 && !is_cont(b1))
                    begin
                        // bad second byte: zero now, reexamine it as a lead
                        unit = '0;
                    end
                    else if (avail < 2'd3)
                    begin
                        if (!fin)
                            stop = 1'b1;
                    end
                    else if (is_cont(b2) && v3 >= THREE_BYTE_MIN)
                    begin
                        unit = v3;
                        used = 2'd3;
                    end
                end
                if (!stop)
                begin
                    r.units[r.n] = unit;
                    r.n          = r.n + 2'd1;
                    head         = head + used;
                end
            end
        end
        r.rem_cnt = cnt - head;
        r.rem[0]  = bufs[head];
        r.rem[1]  = bufs[head + 2'd1];
        return r;
    endfunction

endpackage

[hw/rtl/u8u16_front.sv]
`include "utf8_to_utf16_bmp_decoder_defines.svh"

module u8u16_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  u8u16_pkg::byte_t   byte_in,
    input  logic               final_byte,
    input  logic               q_full,
    output logic               push,
    output u8u16_pkg::entry_t  push_entry
);
    import u8u16_pkg::*;

    byte_t [HELD_MAX-1:0] held_reg;
    byte_t [HELD_MAX-1:0] held_next;
    logic [1:0]           held_count_reg;
    logic [1:0]           held_count_next;
    logic [3:0][7:0]      bufs;
    step_t                step;
    logic                 accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        bufs                 = '0;
        bufs[0]              = held_reg[0];
        bufs[1]              = held_reg[1];
        bufs[held_count_reg] = byte_in;
        step = decode_step(bufs, held_count_reg + 2'd1, final_byte);
    end

    assign push             = accept && (step.n != 2'd0);
    assign push_entry.n     = step.n;
    assign push_entry.fin   = final_byte;
    assign push_entry.units = step.units;

    always_comb
    begin
        held_next       = held_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            held_next       = step.rem;
            held_count_next = step.rem_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_count_reg <= '0;
        end
        else
        begin
            held_reg       <= held_next;
            held_count_reg <= held_count_next;
        end
    end

    // A decode step never leaves more than two pending bytes.
    `U8U16_ASSERT_NOW(a_held_range, 1'b1, held_count_reg != 2'd3, "held count out of range")

endmodule

[hw/rtl/u8u16_queue.sv]
`include "utf8_to_utf16_bmp_decoder_defines.svh"

module u8u16_queue
#(
    parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  u8u16_pkg::entry_t  push_entry,
    input  logic               pop,
    output logic               q_valid,
    output logic               q_full,
    output u8u16_pkg::entry_t  q_head
);
    import u8u16_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          do_push;
    logic          do_pop;

    assign q_valid = cnt_reg != '0;
    assign q_full  = cnt_reg == FULL_CNT;
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `U8U16_ASSERT_NOW(a_q_count, 1'b1, cnt_reg <= FULL_CNT, "queue count overflow")

endmodule

[hw/rtl/u8u16_back.sv]
`include "utf8_to_utf16_bmp_decoder_defines.svh"

module u8u16_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  u8u16_pkg::entry_t  q_head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output u8u16_pkg::unit_t   code_unit,
    output logic               run_last,
    output logic               string_end
);
    import u8u16_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    unit_t      code_unit_reg;
    logic       run_last_reg;
    logic       string_end_reg;
    logic       load;
    logic       last_of_entry;

    // output register is free when empty or being taken this cycle
    assign load          = q_valid && (!valid_reg || !out_stall);
    assign last_of_entry = idx_reg == (q_head.n - 2'd1);
    assign pop           = load && last_of_entry;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = last_of_entry ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_unit_reg  <= q_head.units[idx_reg];
            run_last_reg   <= last_of_entry;
            string_end_reg <= last_of_entry && q_head.fin;
        end
    end

    assign out_valid  = valid_reg;
    assign code_unit  = code_unit_reg;
    assign run_last   = run_last_reg;
    assign string_end = string_end_reg;

    `U8U16_ASSERT_NOW(a_end_is_last, valid_reg && string_end_reg, run_last_reg, "string end not on last result")
    `U8U16_ASSERT_NOW(a_idx_in_entry, q_valid, idx_reg < q_head.n, "result index past entry")
    `U8U16_ASSERT_NEXT(a_pop_rewinds, pop, idx_reg == 2'd0, "index not rewound after pop")

endmodule

[hw/rtl/utf8_to_utf16_bmp_decoder.sv]
// UTF-8 to 16-bit code unit decoder for the Basic Multilingual Plane. One byte is taken per
// cycle while in_stall is low; each byte yields zero to three code units, delivered one per
// cycle while out_stall is low, so valid text (at most one unit per byte) streams at one
// byte per clock. Each unit is registered in the entry queue and then the output register.
// Bad or truncated sequences give unit 0 and drop only their lead byte; a final_byte flushes
// pending bytes. A byte that yields several units stays at the queue head until its last
// unit is loaded; input stalls once the entry queue from front end to output stage is full.
module utf8_to_utf16_bmp_decoder
#(
    parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  u8u16_pkg::byte_t  byte_in,
    input  logic              final_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output u8u16_pkg::unit_t  code_unit,
    output logic              run_last,
    output logic              string_end
);
    import u8u16_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   q_valid;
    logic   q_full;
    entry_t q_head;

    u8u16_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .final_byte (final_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    u8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .q_head     (q_head)
    );

    u8u16_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_unit  (code_unit),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

[tb/sv/u8u16_decode_checker.sv]
module u8u16_decode_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  u8u16_pkg::byte_t  byte_in,
    input  logic              final_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  u8u16_pkg::unit_t  code_unit,
    input  logic              run_last,
    input  logic              string_end,
    output int                fail_count,
    output int                backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    typedef struct packed {
        unit_t unit;
        logic  last;
        logic  send;
    } unit_item_t;

    unit_item_t pending_units [$];
    byte_t      held [0:1];
    int         held_n;
    int         mismatches = 0;

    assign fail_count = mismatches;

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic logic is_tail(input byte_t b);
        return b[7:6] == 2'b10;
    endfunction

    // Decode the held bytes plus the new one; queue every code unit it yields.
    task automatic decode_byte(input byte_t b, input logic fin);
        byte_t      win [0:3];
        unit_item_t res [0:2];
        int         cnt;
        int         head;
        int         avail;
        int         used;
        int         n;
        int         k;
        byte_t      lead;
        unit_t      unit;
        unit_t      v;
        bit         stop;
        for (k = 0; k < 4; k++)
            win[k] = '0;
        for (k = 0; k < held_n; k++)
            win[k] = held[k];
        win[held_n] = b;
        cnt  = held_n + 1;
        head = 0;
        n    = 0;
        stop = 1'b0;
        while (!stop && head < cnt)
        begin
            avail = cnt - head;
            lead  = win[head];
            unit  = '0;
            used  = 1;
            if (!lead[7])
            begin
                unit = {8'h00, lead};
            end
            else if (lead[7:5] == 3'b110)
            begin
                if (avail < 2)
                begin
                    if (!fin)
                        stop = 1'b1;
                end
                else if (is_tail(win[head+1]))
                begin
                    v = {5'b00000, lead[4:0], win[head+1][5:0]};
                    if (v >= {5'b00000, TWO_BYTE_MIN} && v <= 16'h07FF)
                    begin
                        unit = v;
                        used = 2;
                    end
                end
            end
            else if (lead[7:4] == 4'b1110)
            begin
                if (avail >= 2 && !is_tail(win[head+1]))
                begin
                    // bad second byte: zero right away, lead dropped
                    unit = '0;
                end
                else if (avail < 3)
                begin
                    if (!fin)
                        stop = 1'b1;
                end
                else if (is_tail(win[head+2]))
                begin
                    v = {lead[3:0], win[head+1][5:0], win[head+2][5:0]};
                    if (v >= THREE_BYTE_MIN)
                    begin
                        unit = v;
                        used = 3;
                    end
                end
            end
            if (!stop)
            begin
                res[n].unit = unit;
                res[n].last = 1'b0;
                res[n].send = 1'b0;
                n++;
                head += used;
            end
        end
        if (n > 0)
        begin
            res[n-1].last = 1'b1;
            res[n-1].send = fin;
        end
        for (k = 0; k < n; k++)
            pending_units = {pending_units, res[k]};
        held[0] = '0;
        held[1] = '0;
        for (k = 0; k < 2 && head < cnt; k++)
        begin
            held[k] = win[head];
            head++;
        end
        held_n = k;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        unit_item_t want;
        if (!rst_n)
        begin
            pending_units.delete();
            held[0] = '0;
            held[1] = '0;
            held_n  = 0;
            backlog <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_units.size() == 0)
                begin
                    note_mismatch($sformatf("unit %h with nothing outstanding", code_unit));
                end
                else
                begin
                    want = pending_units.pop_front();
                    if (code_unit !== want.unit)
                        note_mismatch($sformatf("code_unit %h, want %h", code_unit, want.unit));
                    if (run_last !== want.last)
                        note_mismatch($sformatf("run_last %b, want %b (unit %h)",
                                                run_last, want.last, want.unit));
                    if (string_end !== want.send)
                        note_mismatch($sformatf("string_end %b, want %b (unit %h)",
                                                string_end, want.send, want.unit));
                end
            end
            if (in_valid && !in_stall)
                decode_byte(byte_in, final_byte);
            backlog <= pending_units.size();
        end
    end

endmodule

[tb/sv/utf8_to_utf16_bmp_decoder_test.sv]
module utf8_to_utf16_bmp_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int ITEM_TARGET = 450;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 300;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  in_valid   = 1'b0;
    logic  in_stall;
    byte_t byte_in    = '0;
    logic  final_byte = 1'b0;
    logic  out_valid;
    logic  out_stall  = 1'b0;
    unit_t code_unit;
    logic  run_last;
    logic  string_end;

    int    fail_count;
    int    backlog;
    int    bytes_sent  = 0;
    int    idle_cycles = 0;
    bit    no_gaps     = 1'b0;
    byte_t text_q [$];
    logic [8:0] directed_seq [0:28];

    int    stall_left = 0;
    int    units_seen = 0;
    int    long_holds = 0;
    int    calm_left  = 0;
    int    pick;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_to_utf16_bmp_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_unit  (code_unit),
        .run_last   (run_last),
        .string_end (string_end)
    );

    u8u16_decode_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_unit  (code_unit),
        .run_last   (run_last),
        .string_end (string_end),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input byte_t b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_in    <= b;
        final_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    function automatic void append_byte(input byte_t b);
        text_q = {text_q, b};
    endfunction

    // Append one character to text_q: well formed, or one of the broken shapes.
    task automatic add_char(input bit clean);
        byte_t lead;
        if (clean)
        begin
            case ($urandom_range(0, 2))
                0: append_byte(byte_t'($urandom_range(8'h00, 8'h7F)));
                1:
                begin
                    append_byte(byte_t'($urandom_range(8'hC2, 8'hDF)));
                    append_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
                end
                default:
                begin
                    lead = byte_t'($urandom_range(8'hE0, 8'hEF));
                    append_byte(lead);
                    if (lead == 8'hE0)
                        append_byte(byte_t'($urandom_range(8'hA0, 8'hBF)));
                    else
                        append_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
                    append_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
                end
            endcase
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: append_byte(byte_t'($urandom_range(8'h00, 8'hFF)));
                1: append_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
                2: append_byte(byte_t'($urandom_range(8'hC0, 8'hDF)));
                3:
                begin
                    append_byte(byte_t'($urandom_range(8'hE0, 8'hEF)));
                    if ($urandom_range(0, 1))
                        append_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
                end
                4:
                begin
                    // overlong forms
                    if ($urandom_range(0, 1))
                    begin
                        append_byte(byte_t'($urandom_range(8'hC0, 8'hC1)));
                    end
                    else
                    begin
                        append_byte(8'hE0);
                        append_byte(byte_t'($urandom_range(8'h80, 8'h9F)));
                    end
                    append_byte(byte_t'($urandom_range(8'h80, 8'hBF)));
                end
                default: append_byte(byte_t'($urandom_range(8'hF0, 8'hFF)));
            endcase
        end
    endtask

    task automatic send_random_string();
        int  chars;
        int  k;
        bit  noise;
        chars = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 12);
        noise = ($urandom_range(0, 99) < 15);
        no_gaps = ($urandom_range(0, 3) == 0);
        text_q.delete();
        for (k = 0; k < chars; k++)
        begin
            if (noise)
                append_byte(byte_t'($urandom_range(8'h00, 8'hFF)));
            else
                add_char($urandom_range(0, 99) < 90);
        end
        for (k = 0; k < text_q.size(); k++)
            send_byte(text_q[k], k == text_q.size() - 1);
    endtask

    // Receiver: random stalls, calm stretches, and a couple of long hold-offs
    // while the sender keeps offering items.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                units_seen = units_seen + 1;
            if (long_holds < 2 && units_seen >= 80 + 220 * long_holds)
            begin
                long_holds = long_holds + 1;
                stall_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                calm_left = calm_left - 1;
                out_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    calm_left = $urandom_range(20, 60);
                    out_stall <= 1'b0;
                end
                else if (pick < 70)
                begin
                    out_stall <= 1'b0;
                end
                else if (pick < 92)
                begin
                    stall_left = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
                else if (pick < 98)
                begin
                    stall_left = $urandom_range(3, 11);
                    out_stall <= 1'b1;
                end
                else
                begin
                    stall_left = $urandom_range(19, 39);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int k;
        directed_seq = '{
            9'h000, 9'h07F,                 // ascii extremes
            9'h0C2, 9'h080,                 // smallest two-byte
            9'h0C1, 9'h0BF,                 // overlong two-byte
            9'h0C2, 9'h041,                 // two-byte lead, no continuation
            9'h0BF, 9'h0F0, 9'h0FF,         // stray continuation, long leads
            9'h0EF, 9'h0BF, 9'h0BF,         // largest three-byte
            9'h0ED, 9'h0A0, 9'h080,         // surrogate passes through
            9'h0E0, 9'h09F, 9'h0BF,         // three-byte below 0x800
            9'h0E1, 9'h041,                 // bad second byte
            9'h0E1, 9'h080, 9'h041,         // bad third byte, three units
            9'h0E1, 9'h180,                 // end of string with lead pending
            9'h0C2, 9'h1E1                  // flush of two broken leads
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        no_gaps = 1'b1;
        for (k = 0; k < 29; k++)
            send_byte(directed_seq[k][7:0], directed_seq[k][8]);

        while (bytes_sent < ITEM_TARGET)
            send_random_string();
        in_valid <= 1'b0;

        // let the backlog count of the last accepted byte settle first
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
